[hdl/bfu_pkg.sv]
// Shared types, constants and helpers for the bilinear feature upsampler.
package bfu_pkg;

  localparam int MAX_SRC_DIM_DEF = 64;
  localparam int MAX_DST_DIM_DEF = 64;
  localparam int FRAC_BITS_DEF   = 8;

  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int COORD_W     = 6;
  localparam int SAMPLE_W    = 16;
  localparam int ODD_W       = COORD_W + 1;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_ROWS = 2'd0,
    CFG_SRC_COLS = 2'd1,
    CFG_DST_ROWS = 2'd2,
    CFG_DST_COLS = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] src_rows;
    logic [CFG_W-1:0] src_cols;
    logic [CFG_W-1:0] dst_rows;
    logic [CFG_W-1:0] dst_cols;
  } size_cfg_t;

  localparam size_cfg_t SIZE_RST = '{
    src_rows: 7'd16,
    src_cols: 7'd16,
    dst_rows: 7'd32,
    dst_cols: 7'd32
  };

  typedef struct packed {
    op_t                        opcode;
    logic [COORD_W-1:0]         row;
    logic [COORD_W-1:0]         col;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AXIS,
    ST_TAPS,
    ST_DRAIN,
    ST_ROUND
  } back_state_t;

  typedef enum logic [1:0] {
    AX_IDLE,
    AX_CHECK,
    AX_DIV,
    AX_POST
  } axis_state_t;

  function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
    int r;
    r = int'(v);
    if (r < 1) begin
      r = 1;
    end else if (r > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

[hdl/bilinear_feature_upsample.sv]
// Bilinear half-pixel resize of one feature-map channel, top level.
// A write beat passes through the input queue and is then stored in the source map; writes
// sustain one beat per cycle while no query is in progress. Query coordinates come from the
// one-bit-per-cycle dividers of the two axis units; one query at a time.
// A two-beat input queue and an output register decouple both sides. Reset restores the
// size registers and clears control state; the source map is undefined until written.
module bilinear_feature_upsample #(
  parameter int MAX_SRC_DIM = bfu_pkg::MAX_SRC_DIM_DEF,
  parameter int MAX_DST_DIM = bfu_pkg::MAX_DST_DIM_DEF,
  parameter int FRAC_BITS   = bfu_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic [bfu_pkg::COORD_W-1:0]         in_row,
  input  logic [bfu_pkg::COORD_W-1:0]         in_col,
  input  logic signed [bfu_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bfu_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bfu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bfu_pkg::CFG_W-1:0]           cfg_data
);
  import bfu_pkg::*;

  size_cfg_t sizes_r;
  logic      item_valid, item_ready;
  item_t     item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sizes_r <= SIZE_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SRC_ROWS: sizes_r.src_rows <= cfg_data;
        CFG_SRC_COLS: sizes_r.src_cols <= cfg_data;
        CFG_DST_ROWS: sizes_r.dst_rows <= cfg_data;
        CFG_DST_COLS: sizes_r.dst_cols <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bfu_front #(
    .MAX_SRC_DIM(MAX_SRC_DIM)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_row      (in_row),
    .in_col      (in_col),
    .in_sample_in(in_sample_in),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item)
  );

  bfu_back #(
    .MAX_SRC_DIM(MAX_SRC_DIM),
    .MAX_DST_DIM(MAX_DST_DIM),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .sizes         (sizes_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out)
  );

endmodule

[hdl/bfu_front.sv]
// Input stage: accepts beats, drops writes outside the store and queues the rest.
module bfu_front #(
  parameter int MAX_SRC_DIM = bfu_pkg::MAX_SRC_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic [bfu_pkg::COORD_W-1:0]         in_row,
  input  logic [bfu_pkg::COORD_W-1:0]         in_col,
  input  logic signed [bfu_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                item_valid,
  input  logic                                item_ready,
  output bfu_pkg::item_t                      item
);
  import bfu_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             in_fire, keep, push, pop;
  item_t            new_item;

  assign in_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign in_fire  = in_valid && in_ready;
  assign keep     = (in_opcode == OP_QUERY) ||
                    ((int'(in_row) < MAX_SRC_DIM) && (int'(in_col) < MAX_SRC_DIM));
  assign push     = in_fire && keep;

  assign item_valid = (count_r != '0);
  assign item       = queue_r[rd_ptr_r];
  assign pop        = item_valid && item_ready;

  always_comb begin
    new_item.opcode = op_t'(in_opcode);
    new_item.row    = in_row;
    new_item.col    = in_col;
    new_item.sample = in_sample_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

[hdl/bfu_axis.sv]
// Per-axis source coordinate unit with a one-bit-per-cycle restoring divider.
module bfu_axis #(
  parameter int MAX_SRC_DIM = bfu_pkg::MAX_SRC_DIM_DEF,
  parameter int MAX_DST_DIM = bfu_pkg::MAX_DST_DIM_DEF,
  parameter int FRAC_BITS   = bfu_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [bfu_pkg::COORD_W-1:0]        idx,
  input  logic [$clog2(MAX_SRC_DIM+1)-1:0]   n,
  input  logic [$clog2(MAX_DST_DIM+1)-1:0]   d,
  output logic                               done,
  output logic [$clog2(MAX_SRC_DIM)-1:0]     lo,
  output logic [$clog2(MAX_SRC_DIM)-1:0]     hi,
  output logic [FRAC_BITS-1:0]               frac
);
  import bfu_pkg::*;

  localparam int SW     = $clog2(MAX_SRC_DIM + 1);
  localparam int DW     = $clog2(MAX_DST_DIM + 1);
  localparam int IW     = $clog2(MAX_SRC_DIM);
  localparam int DEN_W  = DW + 1;
  localparam int QB     = IW + FRAC_BITS;
  localparam int NUM_W  = ODD_W + SW + FRAC_BITS;
  localparam int LIM_W  = DEN_W + SW + FRAC_BITS;
  localparam int CMP_W  = (NUM_W > LIM_W) ? NUM_W : LIM_W;
  localparam int DIV_W  = DEN_W + QB;
  localparam int STEP_W = $clog2(QB + 1);
  localparam int HALF   = 2 ** (FRAC_BITS - 1);

  axis_state_t       state_r, state_nxt;
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic [SW-1:0]     n_r;
  logic [DIV_W-1:0]  rem_r, dsh_r;
  logic [QB-1:0]     q_r;
  logic [STEP_W-1:0] step_r;
  logic              sat_r, done_r;
  logic [IW-1:0]     lo_r, hi_r;
  logic [FRAC_BITS-1:0] frac_r;

  logic [ODD_W-1:0]  odd;
  logic [LIM_W-1:0]  lim;
  logic              sat;
  logic signed [QB:0] pq;
  logic [QB-1:0]     top, p;
  logic [IW-1:0]     p_lo, p_hi;
  logic [SW-1:0]     lo_inc;

  assign odd = {idx, 1'b1};
  assign lim = (LIM_W'(den_r) * LIM_W'(n_r)) << FRAC_BITS;
  assign sat = CMP_W'(num_r) >= CMP_W'(lim);
  assign top = QB'(n_r - 1'b1) << FRAC_BITS;
  assign pq  = $signed({1'b0, q_r}) - (QB+1)'(HALF);

  always_comb begin
    if (sat_r) begin
      p = top;
    end else if (pq < 0) begin
      p = '0;
    end else if (pq[QB-1:0] > top) begin
      p = top;
    end else begin
      p = pq[QB-1:0];
    end
  end

  assign p_lo   = p[QB-1:FRAC_BITS];
  assign lo_inc = SW'(p_lo) + 1'b1;
  assign p_hi   = (lo_inc < n_r) ? IW'(lo_inc) : IW'(n_r - 1'b1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      AX_IDLE: begin
        if (start) begin
          state_nxt = AX_CHECK;
        end
      end
      AX_CHECK: begin
        state_nxt = sat ? AX_POST : AX_DIV;
      end
      AX_DIV: begin
        if (step_r == STEP_W'(1)) begin
          state_nxt = AX_POST;
        end
      end
      AX_POST: begin
        state_nxt = AX_IDLE;
      end
      default: begin
        state_nxt = AX_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AX_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        done_r <= 1'b0;
      end else if (state_r == AX_POST) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= (NUM_W'(odd) * NUM_W'(n)) << FRAC_BITS;
      den_r <= {d, 1'b0};
      n_r   <= n;
    end
    if (state_r == AX_CHECK) begin
      sat_r  <= sat;
      rem_r  <= DIV_W'(num_r);
      dsh_r  <= DIV_W'(den_r) << (QB - 1);
      q_r    <= '0;
      step_r <= STEP_W'(QB);
    end
    if (state_r == AX_DIV) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[QB-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QB-2:0], 1'b0};
      end
      dsh_r  <= dsh_r >> 1;
      step_r <= step_r - 1'b1;
    end
    if (state_r == AX_POST) begin
      lo_r   <= p_lo;
      hi_r   <= p_hi;
      frac_r <= p[FRAC_BITS-1:0];
    end
  end

  assign done = done_r;
  assign lo   = lo_r;
  assign hi   = hi_r;
  assign frac = frac_r;

endmodule

[hdl/bfu_back.sv]
// Execution stage: source map memory, coordinate units and the four-tap blend.
module bfu_back #(
  parameter int MAX_SRC_DIM = bfu_pkg::MAX_SRC_DIM_DEF,
  parameter int MAX_DST_DIM = bfu_pkg::MAX_DST_DIM_DEF,
  parameter int FRAC_BITS   = bfu_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  bfu_pkg::item_t                      item,
  input  bfu_pkg::size_cfg_t                  sizes,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bfu_pkg::SAMPLE_W-1:0] out_sample_out
);
  import bfu_pkg::*;

  localparam int SW        = $clog2(MAX_SRC_DIM + 1);
  localparam int DW        = $clog2(MAX_DST_DIM + 1);
  localparam int IW        = $clog2(MAX_SRC_DIM);
  localparam int MEM_DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int WGT_W     = 2 * FRAC_BITS + 1;
  localparam int PROD_W    = SAMPLE_W + WGT_W + 1;
  localparam int ACC_W     = PROD_W + 2;
  localparam int RS_W      = ACC_W - 2 * FRAC_BITS;

  localparam logic [FRAC_BITS:0]      ONE_FX = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< (2 * FRAC_BITS - 1);

  back_state_t state_r, state_nxt;

  logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_r;
  logic [MEM_AW-1:0]          mem_addr, wr_addr, rd_addr;
  logic                       mem_we, mem_re;

  logic [SW-1:0] nr, nc;
  logic [DW-1:0] dr, dc;
  logic          ax_start, row_done, col_done;
  logic [IW-1:0] h0, h1, w0, w1, rd_row, rd_col;
  logic [FRAC_BITS-1:0] fh, fw;

  logic [1:0]              tap_r;
  logic [FRAC_BITS:0]      wh, ww;
  logic [WGT_W-1:0]        weight, rd_w_r;
  logic                    rd_vld_r, prod_vld_r;
  logic signed [PROD_W-1:0] a_ext, w_ext, prod_r;
  logic signed [ACC_W-1:0] acc_r, rsum;
  logic signed [RS_W-1:0]  rs;
  logic signed [SAMPLE_W-1:0] sat_val, out_sample_r;
  logic                    out_valid_r, acc_clr, load_out;

  assign nr = SW'(clamp_dim(sizes.src_rows, MAX_SRC_DIM));
  assign nc = SW'(clamp_dim(sizes.src_cols, MAX_SRC_DIM));
  assign dr = DW'(clamp_dim(sizes.dst_rows, MAX_DST_DIM));
  assign dc = DW'(clamp_dim(sizes.dst_cols, MAX_DST_DIM));

  bfu_axis #(
    .MAX_SRC_DIM(MAX_SRC_DIM),
    .MAX_DST_DIM(MAX_DST_DIM),
    .FRAC_BITS  (FRAC_BITS)
  ) u_axis_row (
    .clk  (clk),
    .rst_n(rst_n),
    .start(ax_start),
    .idx  (item.row),
    .n    (nr),
    .d    (dr),
    .done (row_done),
    .lo   (h0),
    .hi   (h1),
    .frac (fh)
  );

  bfu_axis #(
    .MAX_SRC_DIM(MAX_SRC_DIM),
    .MAX_DST_DIM(MAX_DST_DIM),
    .FRAC_BITS  (FRAC_BITS)
  ) u_axis_col (
    .clk  (clk),
    .rst_n(rst_n),
    .start(ax_start),
    .idx  (item.col),
    .n    (nc),
    .d    (dc),
    .done (col_done),
    .lo   (w0),
    .hi   (w1),
    .frac (fw)
  );

  // Tap order: upper-left, upper-right, lower-left, lower-right.
  assign rd_row = tap_r[1] ? h1 : h0;
  assign rd_col = tap_r[0] ? w1 : w0;
  assign wh     = tap_r[1] ? {1'b0, fh} : (ONE_FX - {1'b0, fh});
  assign ww     = tap_r[0] ? {1'b0, fw} : (ONE_FX - {1'b0, fw});
  assign weight = WGT_W'(wh) * WGT_W'(ww);

  assign wr_addr  = MEM_AW'(MEM_AW'(IW'(item.row)) * MEM_AW'(MAX_SRC_DIM) +
                            MEM_AW'(IW'(item.col)));
  assign rd_addr  = MEM_AW'(MEM_AW'(rd_row) * MEM_AW'(MAX_SRC_DIM) + MEM_AW'(rd_col));
  assign mem_addr = mem_we ? wr_addr : rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= item.sample;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    item_ready = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    ax_start   = 1'b0;
    acc_clr    = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (item.opcode == OP_WRITE) begin
            mem_we = 1'b1;
          end else begin
            ax_start  = 1'b1;
            state_nxt = ST_AXIS;
          end
        end
      end
      ST_AXIS: begin
        if (row_done && col_done) begin
          acc_clr   = 1'b1;
          state_nxt = ST_TAPS;
        end
      end
      ST_TAPS: begin
        mem_re = 1'b1;
        if (&tap_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !prod_vld_r) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_r       <= '0;
      rd_vld_r    <= 1'b0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_vld_r   <= mem_re;
      prod_vld_r <= rd_vld_r;
      if (mem_re) begin
        tap_r <= tap_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign a_ext = PROD_W'(rdata_r);
  assign w_ext = PROD_W'($signed({1'b0, rd_w_r}));

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_w_r <= weight;
    end
    if (rd_vld_r) begin
      prod_r <= a_ext * w_ext;
    end
    if (acc_clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (load_out) begin
      out_sample_r <= sat_val;
    end
  end

  assign rsum = acc_r + RND;
  assign rs   = RS_W'(rsum >>> (2 * FRAC_BITS));

  always_comb begin
    if (rs > RS_W'(32767)) begin
      sat_val = SAMPLE_W'(32767);
    end else if (rs < RS_W'(-32768)) begin
      sat_val = SAMPLE_W'(-32768);
    end else begin
      sat_val = SAMPLE_W'(rs);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

[sim/bilinear_feature_upsample_tb.sv]
// Self-checking testbench for the bilinear half-pixel feature-map upsampler.
import bfu_pkg::*;

class resize_checker;
  logic [CFG_W-1:0]           size_reg [4];
  logic signed [SAMPLE_W-1:0] feature_map [MAX_SRC_DIM_DEF*MAX_SRC_DIM_DEF];
  logic signed [SAMPLE_W-1:0] expected_samples [$];
  int                         errors;

  function new();
    size_reg[CFG_SRC_ROWS] = SIZE_RST.src_rows;
    size_reg[CFG_SRC_COLS] = SIZE_RST.src_cols;
    size_reg[CFG_DST_ROWS] = SIZE_RST.dst_rows;
    size_reg[CFG_DST_COLS] = SIZE_RST.dst_cols;
    foreach (feature_map[k]) begin
      feature_map[k] = '0;
    end
    errors = 0;
  endfunction

  function int fit_dim(input logic [CFG_W-1:0] v, input int top);
    if (v == 0) begin
      return 1;
    end
    if (int'(v) > top) begin
      return top;
    end
    return int'(v);
  endfunction

  function void map_axis(input int idx, input int n, input int d,
                         output int lo, output int hi, output int frac);
    longint scale;
    longint num;
    longint p;
    longint top;
    scale = longint'(1) << FRAC_BITS_DEF;
    num = longint'(2 * idx + 1) * longint'(n) * scale;
    p = num / longint'(2 * d) - (scale >> 1);
    top = longint'(n - 1) * scale;
    if (p < 0) begin
      p = 0;
    end
    if (p > top) begin
      p = top;
    end
    lo = int'(p >> FRAC_BITS_DEF);
    hi = (lo + 1 < n) ? lo + 1 : n - 1;
    frac = int'(p & (scale - 1));
  endfunction

  function logic signed [SAMPLE_W-1:0] interp_sample(input int row, input int col);
    int     h0, h1, w0, w1, fh, fw;
    longint scale, v00, v01, v10, v11, acc;
    map_axis(row, fit_dim(size_reg[CFG_SRC_ROWS], MAX_SRC_DIM_DEF),
             fit_dim(size_reg[CFG_DST_ROWS], MAX_DST_DIM_DEF), h0, h1, fh);
    map_axis(col, fit_dim(size_reg[CFG_SRC_COLS], MAX_SRC_DIM_DEF),
             fit_dim(size_reg[CFG_DST_COLS], MAX_DST_DIM_DEF), w0, w1, fw);
    scale = longint'(1) << FRAC_BITS_DEF;
    v00 = feature_map[h0 * MAX_SRC_DIM_DEF + w0];
    v01 = feature_map[h0 * MAX_SRC_DIM_DEF + w1];
    v10 = feature_map[h1 * MAX_SRC_DIM_DEF + w0];
    v11 = feature_map[h1 * MAX_SRC_DIM_DEF + w1];
    acc = v00 * (scale - fh) * (scale - fw) + v01 * (scale - fh) * fw
        + v10 * fh * (scale - fw) + v11 * fh * fw;
    acc = acc + (longint'(1) << (2 * FRAC_BITS_DEF - 1));
    acc = acc >>> (2 * FRAC_BITS_DEF);
    if (acc > 32767) begin
      acc = 32767;
    end
    if (acc < -32768) begin
      acc = -32768;
    end
    return acc[SAMPLE_W-1:0];
  endfunction

  function void set_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    size_reg[idx] = v;
  endfunction

  function void note_input(input op_t op, input logic [COORD_W-1:0] row,
                           input logic [COORD_W-1:0] col,
                           input logic signed [SAMPLE_W-1:0] sample);
    if (op == OP_WRITE) begin
      feature_map[int'(row) * MAX_SRC_DIM_DEF + int'(col)] = sample;
    end else begin
      expected_samples.push_back(interp_sample(int'(row), int'(col)));
    end
  endfunction

  function void check_result(input logic signed [SAMPLE_W-1:0] got);
    logic signed [SAMPLE_W-1:0] want;
    if (expected_samples.size() == 0) begin
      errors++;
      $display("%0t: sample_out expected none, actual %0d", $time, got);
    end else begin
      want = expected_samples.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: sample_out expected %0d, actual %0d", $time, want, got);
      end
    end
  endfunction

  function int pending();
    return expected_samples.size();
  endfunction
endclass

module bilinear_feature_upsample_tb;
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int SETTLE_CYCLES    = 40;
  localparam int RANDOM_PER_PHASE = 110;
  localparam int HOLD_CYCLES      = 300;
  localparam int MAP_W            = MAX_SRC_DIM_DEF;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_opcode;
  logic [COORD_W-1:0]         in_row;
  logic [COORD_W-1:0]         in_col;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_data;

  resize_checker    board;
  bit               filled [MAP_W*MAP_W];
  logic [CFG_W-1:0] gen_size [4];
  int               tx_idle_pct;
  int               rx_stall_pct;
  logic             hold_rx;
  int               quiet_cycles;
  int               size_plan [8][4] = '{
    '{1, 1, 1, 1}, '{64, 64, 64, 64}, '{0, 0, 0, 0}, '{127, 127, 127, 127},
    '{5, 9, 64, 3}, '{64, 1, 2, 64}, '{13, 37, 50, 20}, '{3, 64, 64, 7}
  };

  bilinear_feature_upsample dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_opcode(in_opcode),
    .in_row(in_row),
    .in_col(in_col),
    .in_sample_in(in_sample_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sample_out(out_sample_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    out_ready <= !hold_rx && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        board.note_input(op_t'(in_opcode), in_row, in_col, in_sample_in);
      end
      if (out_valid && out_ready) begin
        board.check_result(out_sample_out);
      end
      if (cfg_valid && cfg_ready) begin
        board.set_size(cfg_index, cfg_data);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(input op_t op, input int row, input int col,
                           input logic signed [SAMPLE_W-1:0] sample);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_row <= row[COORD_W-1:0];
    in_col <= col[COORD_W-1:0];
    in_sample_in <= sample;
    if (op == OP_WRITE) begin
      filled[row * MAP_W + col] = 1'b1;
    end
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(3))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
    return SAMPLE_W'($urandom);
  endfunction

  task automatic fill_entry(input int r, input int c);
    if (!filled[r * MAP_W + c]) begin
      send_item(OP_WRITE, r, c, pick_sample());
    end
  endtask

  // Every neighbor a query will blend is written first, so no unwritten entry is read.
  task automatic query_at(input int row, input int col);
    int h0, h1, w0, w1, fh, fw;
    board.map_axis(row, board.fit_dim(gen_size[CFG_SRC_ROWS], MAX_SRC_DIM_DEF),
                   board.fit_dim(gen_size[CFG_DST_ROWS], MAX_DST_DIM_DEF), h0, h1, fh);
    board.map_axis(col, board.fit_dim(gen_size[CFG_SRC_COLS], MAX_SRC_DIM_DEF),
                   board.fit_dim(gen_size[CFG_DST_COLS], MAX_DST_DIM_DEF), w0, w1, fw);
    fill_entry(h0, w0);
    fill_entry(h0, w1);
    fill_entry(h1, w0);
    fill_entry(h1, w1);
    send_item(OP_QUERY, row, col, SAMPLE_W'($urandom));
  endtask

  task automatic write_size(input cfg_idx_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    gen_size[idx] = value[CFG_W-1:0];
    do begin
      @(posedge clk);
    end while (!cfg_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_traffic(input int count);
    int dr, dc, sr, sc, row, col;
    dr = board.fit_dim(gen_size[CFG_DST_ROWS], MAX_DST_DIM_DEF);
    dc = board.fit_dim(gen_size[CFG_DST_COLS], MAX_DST_DIM_DEF);
    sr = board.fit_dim(gen_size[CFG_SRC_ROWS], MAX_SRC_DIM_DEF);
    sc = board.fit_dim(gen_size[CFG_SRC_COLS], MAX_SRC_DIM_DEF);
    repeat (count) begin
      if ($urandom_range(99) < 55) begin
        if ($urandom_range(99) < 85) begin
          row = $urandom_range(dr - 1);
          col = $urandom_range(dc - 1);
        end else begin
          row = $urandom_range(MAP_W - 1);
          col = $urandom_range(MAP_W - 1);
        end
        query_at(row, col);
      end else begin
        if ($urandom_range(99) < 60) begin
          row = $urandom_range(sr - 1);
          col = $urandom_range(sc - 1);
        end else begin
          row = $urandom_range(MAP_W - 1);
          col = $urandom_range(MAP_W - 1);
        end
        send_item(OP_WRITE, row, col, pick_sample());
      end
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_WRITE;
    in_row = '0;
    in_col = '0;
    in_sample_in = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SRC_ROWS;
    cfg_data = '0;
    hold_rx = 1'b0;
    quiet_cycles = 0;
    tx_idle_pct = 21;
    rx_stall_pct = 51;
    gen_size[CFG_SRC_ROWS] = SIZE_RST.src_rows;
    gen_size[CFG_SRC_COLS] = SIZE_RST.src_cols;
    gen_size[CFG_DST_ROWS] = SIZE_RST.dst_rows;
    gen_size[CFG_DST_COLS] = SIZE_RST.dst_cols;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_item(OP_WRITE, 0, 0, 16'sh7FFF);
    send_item(OP_WRITE, 0, 1, 16'sh8000);
    send_item(OP_WRITE, 1, 0, 16'sh8000);
    send_item(OP_WRITE, 1, 1, 16'sh7FFF);
    send_item(OP_WRITE, 63, 63, 16'shFFFF);
    send_item(OP_WRITE, 63, 0, 16'sh0000);
    send_item(OP_WRITE, 15, 15, 16'sh7FFF);
    query_at(0, 0);
    query_at(1, 1);
    query_at(2, 2);
    query_at(31, 31);
    query_at(63, 63);
    query_at(0, 63);
    query_at(63, 0);
    query_at(17, 30);
    drain_results();

    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        tx_idle_pct = 51;
        rx_stall_pct <= 21;
      end
      if (p == 6) begin
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
      end
      write_size(CFG_SRC_ROWS, size_plan[p][0]);
      write_size(CFG_SRC_COLS, size_plan[p][1]);
      write_size(CFG_DST_ROWS, size_plan[p][2]);
      write_size(CFG_DST_COLS, size_plan[p][3]);
      cfg_valid <= 1'b0;
      if (p == 6) begin
        fork
          begin
            hold_rx <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_rx <= 1'b0;
          end
        join_none
        repeat (24) begin
          query_at($urandom_range(MAP_W - 1), $urandom_range(MAP_W - 1));
        end
      end
      random_traffic(RANDOM_PER_PHASE);
      drain_results();
    end

    if (board.errors == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
